// ===== rtl/core/lbel_pkg.sv =====
`timescale 1ns / 1ps

package lbel_pkg;

  // field widths fixed by the word formats
  localparam int unsigned LevelW = 7;
  localparam int unsigned TimeW  = 17;
  localparam int unsigned DateW  = 16;
  localparam int unsigned ViewW  = 8;
  localparam int unsigned ClassW = 2;
  localparam int unsigned StampW = TimeW + DateW;
  localparam int unsigned ClsLvlW = ClassW + LevelW;

  // register file
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegThrLow  = 1'b0;
  localparam logic [CfgAddrW-1:0] RegThrHigh = 1'b1;
  localparam logic [LevelW-1:0] ThrLowReset  = 7'd20;
  localparam logic [LevelW-1:0] ThrHighReset = 7'd80;

  // command codes carried on tuser
  localparam logic CmdSample = 1'b0;
  localparam logic CmdRead   = 1'b1;

  typedef enum logic [ClassW-1:0] {
    CLS_OK   = 2'd0,
    CLS_LOW  = 2'd1,
    CLS_HIGH = 2'd2
  } class_e;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/level_band_event_logger.sv =====
// latency: a word accepted at one edge has its result word valid from the next cycle on
// handshake: a new word is taken only after the previous result word has been taken by the sink,
//   set by the accept/respond controller around the event memory read or write
// reset (rst_ni low, asynchronous): class OK, log empty, thresholds 20 and 80;
//   event memory contents are not cleared and need no clearing pass
`timescale 1ns / 1ps

module level_band_event_logger #(
  parameter int unsigned LOG_DEPTH = 16,
  localparam int unsigned CntW     = $clog2(LOG_DEPTH + 1),
  localparam int unsigned OutBitsW = 79 + CntW,
  localparam int unsigned OutDataW = ((OutBitsW + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [lbel_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [lbel_pkg::LevelW-1:0]    cfg_wdata_i,
  // input stream
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  // sample_lvl[6:0], now_time[23:7], now_date[39:24], read_age[47:40]
  input  logic [47:0]                    s_tdata_i,
  // command: 0 level sample, 1 read event by age index
  input  logic                           s_tuser_i,
  // result stream
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // live_class, entry_count, entry_valid, entry_class, entry_level,
  // start_time, start_date, end_time, end_date, entry_closed, zero pad
  output logic [OutDataW-1:0]            m_tdata_o
);

  // controller to datapath
  lbel_pkg::ctrl_cmd_t cmd;

  // input word fields
  logic [lbel_pkg::LevelW-1:0] sample_lvl;
  logic [lbel_pkg::TimeW-1:0]  now_time;
  logic [lbel_pkg::DateW-1:0]  now_date;
  logic [lbel_pkg::ViewW-1:0]  read_age;

  assign sample_lvl = s_tdata_i[6:0];
  assign now_time   = s_tdata_i[23:7];
  assign now_date   = s_tdata_i[39:24];
  assign read_age   = s_tdata_i[47:40];

  // result fields
  logic [lbel_pkg::ClassW-1:0] live_class;
  logic [CntW-1:0]             entry_count;
  logic                        entry_valid;
  logic [lbel_pkg::ClassW-1:0] entry_class;
  logic [lbel_pkg::LevelW-1:0] entry_level;
  logic [lbel_pkg::TimeW-1:0]  start_time;
  logic [lbel_pkg::DateW-1:0]  start_date;
  logic [lbel_pkg::TimeW-1:0]  end_time;
  logic [lbel_pkg::DateW-1:0]  end_date;
  logic                        entry_closed;

  // two-state handshake sequencer: take a word, then present its result
  // until the sink takes it; datapath state holds steady meanwhile
  lbel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .cmd_o       (cmd)
  );

  // classification, ring pointers and event memories; samples update the
  // log at the accept edge, reads latch the addressed entry at that edge
  lbel_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .command_i       (s_tuser_i),
    .sample_lvl_i    (sample_lvl),
    .now_time_i      (now_time),
    .now_date_i      (now_date),
    .read_age_i      (read_age),
    .live_class_o    (live_class),
    .entry_count_o   (entry_count),
    .entry_valid_o   (entry_valid),
    .entry_class_o   (entry_class),
    .entry_level_o   (entry_level),
    .start_time_o    (start_time),
    .start_date_o    (start_date),
    .end_time_o      (end_time),
    .end_date_o      (end_date),
    .entry_closed_o  (entry_closed)
  );

  // pack the result word, first field lowest, zero fill to whole bytes
  assign m_tdata_o = OutDataW'({entry_closed, end_date, end_time, start_date, start_time,
                                entry_level, entry_class, entry_valid, entry_count,
                                live_class});

endmodule

// ===== rtl/core/lbel_ctrl.sv =====
`timescale 1ns / 1ps

module lbel_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lbel_pkg::ctrl_cmd_t  cmd_o
);

  lbel_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbel_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.accept = 1'b0;
    case (state_q)
      lbel_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = lbel_pkg::ST_RESP;
        end
      end
      lbel_pkg::ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = lbel_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lbel_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/lbel_dp.sv =====
`timescale 1ns / 1ps

module lbel_dp #(
  parameter int unsigned LOG_DEPTH = 16,
  localparam int unsigned CntW = $clog2(LOG_DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lbel_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [lbel_pkg::LevelW-1:0]      cfg_wdata_i,
  input  lbel_pkg::ctrl_cmd_t              cmd_i,
  input  logic                             command_i,
  input  logic [lbel_pkg::LevelW-1:0]      sample_lvl_i,
  input  logic [lbel_pkg::TimeW-1:0]       now_time_i,
  input  logic [lbel_pkg::DateW-1:0]       now_date_i,
  input  logic [lbel_pkg::ViewW-1:0]       read_age_i,
  output logic [lbel_pkg::ClassW-1:0]      live_class_o,
  output logic [CntW-1:0]                  entry_count_o,
  output logic                             entry_valid_o,
  output logic [lbel_pkg::ClassW-1:0]      entry_class_o,
  output logic [lbel_pkg::LevelW-1:0]      entry_level_o,
  output logic [lbel_pkg::TimeW-1:0]       start_time_o,
  output logic [lbel_pkg::DateW-1:0]       start_date_o,
  output logic [lbel_pkg::TimeW-1:0]       end_time_o,
  output logic [lbel_pkg::DateW-1:0]       end_date_o,
  output logic                             entry_closed_o
);

  localparam int unsigned PtrW = $clog2(LOG_DEPTH);
  localparam int unsigned SumW = PtrW + 1;
  localparam int unsigned CmpW = (CntW > lbel_pkg::ViewW) ? CntW : lbel_pkg::ViewW;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(LOG_DEPTH - 1);
  localparam logic [SumW-1:0] DepthS  = SumW'(LOG_DEPTH);
  localparam logic [CntW-1:0] CntFull = CntW'(LOG_DEPTH);

  // thresholds
  logic [lbel_pkg::LevelW-1:0] thr_low_q, thr_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_low_q  <= lbel_pkg::ThrLowReset;
      thr_high_q <= lbel_pkg::ThrHighReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lbel_pkg::RegThrLow:  thr_low_q  <= cfg_wdata_i;
        lbel_pkg::RegThrHigh: thr_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // log state
  lbel_pkg::class_e class_q, class_d, cls;
  logic [PtrW-1:0]  wp_q, wp_d, wp_prev, wp_next;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             last_open_q, last_open_d;
  logic             rd_valid_q;

  logic push, close_ev, is_sample, hit;
  logic [SumW-1:0] sum;
  logic [PtrW-1:0] rd_idx;
  logic [lbel_pkg::StampW-1:0] now_stamp;

  assign now_stamp = {now_date_i, now_time_i};
  assign is_sample = cmd_i.accept && (command_i == lbel_pkg::CmdSample);
  assign hit       = CmpW'(read_age_i) < CmpW'(cnt_q);
  assign wp_prev   = (wp_q == '0) ? PtrLast : wp_q - PtrW'(1);
  assign wp_next   = (wp_q == PtrLast) ? '0 : wp_q + PtrW'(1);

  // oldest + age, one wrap at most since the age is below the count
  assign sum    = SumW'(wp_q) + DepthS - SumW'(cnt_q) + SumW'(read_age_i);
  assign rd_idx = (sum >= DepthS) ? PtrW'(sum - DepthS) : PtrW'(sum);

  always_comb begin
    if (sample_lvl_i < thr_low_q) begin
      cls = lbel_pkg::CLS_LOW;
    end else if (sample_lvl_i > thr_high_q) begin
      cls = lbel_pkg::CLS_HIGH;
    end else begin
      cls = lbel_pkg::CLS_OK;
    end
  end

  always_comb begin
    push        = 1'b0;
    close_ev    = 1'b0;
    class_d     = class_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    last_open_d = last_open_q;
    if (is_sample && (cls != class_q)) begin
      class_d = cls;
      case (cls)
        lbel_pkg::CLS_OK: begin
          // newest event closes once; an empty log never reports open
          if (last_open_q) begin
            close_ev    = 1'b1;
            last_open_d = 1'b0;
          end
        end
        default: begin
          push        = 1'b1;
          wp_d        = wp_next;
          last_open_d = 1'b1;
          if (cnt_q != CntFull) begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q     <= lbel_pkg::CLS_OK;
      wp_q        <= '0;
      cnt_q       <= '0;
      last_open_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      class_q     <= class_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      last_open_q <= last_open_d;
      if (cmd_i.accept) begin
        rd_valid_q <= (command_i == lbel_pkg::CmdRead) && hit;
      end
    end
  end

  // event memories, one write and one registered read each
  logic [lbel_pkg::ClsLvlW-1:0] mem_cl    [LOG_DEPTH];
  logic [lbel_pkg::StampW-1:0]  mem_start [LOG_DEPTH];
  logic [lbel_pkg::StampW-1:0]  mem_end   [LOG_DEPTH];
  logic                         mem_closed[LOG_DEPTH];

  logic [lbel_pkg::ClsLvlW-1:0] rd_cl_q;
  logic [lbel_pkg::StampW-1:0]  rd_start_q, rd_end_q;
  logic                         rd_closed_q;
  logic                         rd_en;
  logic [PtrW-1:0]              flag_addr;

  assign rd_en     = cmd_i.accept && (command_i == lbel_pkg::CmdRead);
  assign flag_addr = push ? wp_q : wp_prev;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_cl[wp_q]    <= {cls, sample_lvl_i};
      mem_start[wp_q] <= now_stamp;
    end
    if (close_ev) begin
      mem_end[wp_prev] <= now_stamp;
    end
    if (push || close_ev) begin
      mem_closed[flag_addr] <= close_ev;
    end
    if (rd_en) begin
      rd_cl_q     <= mem_cl[rd_idx];
      rd_start_q  <= mem_start[rd_idx];
      rd_end_q    <= mem_end[rd_idx];
      rd_closed_q <= mem_closed[rd_idx];
    end
  end

  logic show_end;
  assign show_end = rd_valid_q && rd_closed_q;

  assign live_class_o   = class_q;
  assign entry_count_o  = cnt_q;
  assign entry_valid_o  = rd_valid_q;
  assign entry_class_o  = rd_valid_q ? rd_cl_q[lbel_pkg::ClsLvlW-1:lbel_pkg::LevelW] : '0;
  assign entry_level_o  = rd_valid_q ? rd_cl_q[lbel_pkg::LevelW-1:0] : '0;
  assign start_time_o   = rd_valid_q ? rd_start_q[lbel_pkg::TimeW-1:0] : '0;
  assign start_date_o   = rd_valid_q ? rd_start_q[lbel_pkg::StampW-1:lbel_pkg::TimeW] : '0;
  assign end_time_o     = show_end ? rd_end_q[lbel_pkg::TimeW-1:0] : '0;
  assign end_date_o     = show_end ? rd_end_q[lbel_pkg::StampW-1:lbel_pkg::TimeW] : '0;
  assign entry_closed_o = show_end;

endmodule
